FILE: rtl/core/mandel_pkg.sv
package mandel_pkg;

   localparam int FracBits  = 28;
   localparam int IterCap   = 256;
   localparam int PixelBits = 12;
   localparam int CountBits = 9;

   localparam logic [2:0] CsrOriginX = 3'd0;
   localparam logic [2:0] CsrOriginY = 3'd1;
   localparam logic [2:0] CsrStepX   = 3'd2;
   localparam logic [2:0] CsrStepY   = 3'd3;
   localparam logic [2:0] CsrMaxIter = 3'd4;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic               hit;
   } job_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sd2147483647)
         r = 32'sh7fffffff;
      else if (v < -48'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

   function automatic logic [63:0] sq_sat(input logic signed [32:0] v);
      logic [32:0] m;
      logic [63:0] r;
      m = v[32] ? 33'(-v) : 33'(v);
      if (m[32])
         r = '1;
      else
         r = m[31:0] * m[31:0];
      return r;
   endfunction

endpackage

FILE: rtl/core/mandel_front.sv
module mandel_front #(
   parameter int FRAC_BITS  = mandel_pkg::FracBits,
   parameter int PIXEL_BITS = mandel_pkg::PixelBits
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [PIXEL_BITS-1:0]   in_col,
   input  logic [PIXEL_BITS-1:0]   in_row,
   input  logic signed [31:0]      origin_x,
   input  logic signed [31:0]      origin_y,
   input  logic [30:0]             step_x,
   input  logic [30:0]             step_y,
   output logic                    out_valid,
   input  logic                    out_ready,
   output mandel_pkg::job_type     out_job
);
   // phases: map, squares, sums, sqrt (32 steps), p squared, compare
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StMap  = 3'd1;
   localparam logic [2:0] StSq   = 3'd2;
   localparam logic [2:0] StSum  = 3'd3;
   localparam logic [2:0] StRoot = 3'd4;
   localparam logic [2:0] StPsq  = 3'd5;
   localparam logic [2:0] StCmp  = 3'd6;
   localparam logic [2:0] StOut  = 3'd7;
   localparam logic signed [33:0] Quarter = 34'sd1 <<< (FRAC_BITS - 2);
   localparam logic signed [33:0] One     = 34'sd1 <<< FRAC_BITS;

   logic [2:0] state_ff, state_in;
   logic [PIXEL_BITS-1:0] col_ff, row_ff;
   logic signed [31:0] cx_ff, cy_ff;
   logic [63:0] xq_ff, yq_ff, bq_ff;
   logic [63:0] rem_ff, res_ff, bit_ff;
   logic [63:0] p2_ff;
   logic hit_ff;
   logic [63:0] sum_a, sum_b, trial;
   logic signed [65:0] lhs, rhs;

   assign in_ready  = (state_ff == StIdle);
   assign out_valid = (state_ff == StOut);
   assign out_job   = '{cx: cx_ff, cy: cy_ff, hit: hit_ff};

   assign sum_a = xq_ff + yq_ff;
   assign sum_b = bq_ff + yq_ff;
   assign trial = res_ff + bit_ff;
   assign lhs = 66'(cx_ff) + 66'(p2_ff << 1);
   assign rhs = $signed({2'b00, res_ff}) + 66'(Quarter);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: if (in_valid) state_in = StMap;
         StMap:  state_in = StSq;
         StSq:   state_in = StSum;
         StSum:  state_in = StRoot;
         StRoot: if (bit_ff == '0) state_in = StPsq;
         StPsq:  state_in = StCmp;
         StCmp:  state_in = StOut;
         StOut:  if (out_ready) state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= StIdle;
      else
         state_ff <= state_in;
      case (state_ff)
         StIdle: begin
            col_ff <= in_col;
            row_ff <= in_row;
         end
         StMap: begin
            cx_ff <= mandel_pkg::sat32(48'(origin_x) + $signed(48'(col_ff) * 48'(step_x)));
            cy_ff <= mandel_pkg::sat32(48'(origin_y) - $signed(48'(row_ff) * 48'(step_y)));
         end
         StSq: begin
            xq_ff <= mandel_pkg::sq_sat(33'(34'(cx_ff) - Quarter));
            yq_ff <= mandel_pkg::sq_sat(33'(cy_ff));
            bq_ff <= mandel_pkg::sq_sat(33'(34'(cx_ff) + One));
         end
         StSum: begin
            rem_ff <= (sum_a < xq_ff) ? '1 : sum_a;
            bq_ff  <= (sum_b < bq_ff) ? '1 : sum_b;
            res_ff <= '0;
            bit_ff <= 64'd1 << 62;
         end
         StRoot: begin
            if (bit_ff != '0) begin
               if (rem_ff >= trial) begin
                  rem_ff <= rem_ff - trial;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end
         end
         StPsq: p2_ff <= (res_ff[31:0] * res_ff[31:0]) >> FRAC_BITS;
         StCmp:
            hit_ff <= (lhs < rhs) ||
                      ((bq_ff >> FRAC_BITS) < (64'd1 << (FRAC_BITS - 4)));
         default: ;
      endcase
   end
endmodule

FILE: rtl/core/mandel_queue.sv
module mandel_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  mandel_pkg::job_type in_job,
   output logic                out_valid,
   input  logic                out_ready,
   output mandel_pkg::job_type out_job
);
   mandel_pkg::job_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_job;
   end
endmodule

FILE: rtl/core/mandel_back.sv
module mandel_back #(
   parameter int FRAC_BITS = mandel_pkg::FracBits,
   parameter int ITER_CAP  = mandel_pkg::IterCap
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  mandel_pkg::job_type in_job,
   input  logic [8:0]          max_iter,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [8:0]          out_count,
   output logic                out_hit
);
   // per iteration: test and square (A), then add c (B)
   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StA    = 2'd1;
   localparam logic [1:0] StB    = 2'd2;
   localparam logic [1:0] StOut  = 2'd3;
   localparam int CW = $clog2(ITER_CAP + 1);

   logic [1:0] state_ff, state_in;
   logic signed [31:0] cx_ff, cy_ff, zx_ff, zy_ff;
   logic signed [63:0] xx_ff, yy_ff, xy_ff;
   logic [CW-1:0] cnt_ff, lim_ff, lim_in;
   logic hit_ff;
   logic [64:0] r2;
   logic done;
   logic signed [64:0] dx;

   assign r2   = 65'(mandel_pkg::sq_sat(33'(zx_ff))) + 65'(mandel_pkg::sq_sat(33'(zy_ff)));
   assign done = (cnt_ff >= lim_ff) || ((r2 >> FRAC_BITS) >= (65'd4 << FRAC_BITS));
   assign dx   = 65'(xx_ff) - 65'(yy_ff);
   assign lim_in = (32'(max_iter) > ITER_CAP) ? CW'(ITER_CAP) : CW'(max_iter);

   assign in_ready  = (state_ff == StIdle);
   assign out_valid = (state_ff == StOut);
   assign out_count = hit_ff ? 9'd0 : 9'(cnt_ff);
   assign out_hit   = hit_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: if (in_valid) state_in = in_job.hit ? StOut : StA;
         StA:    if (done) state_in = StOut; else state_in = StB;
         StB:    state_in = StA;
         StOut:  if (out_ready) state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= StIdle;
      else
         state_ff <= state_in;
      unique case (state_ff)
         StIdle: begin
            cx_ff  <= in_job.cx;
            cy_ff  <= in_job.cy;
            hit_ff <= in_job.hit;
            zx_ff  <= '0;
            zy_ff  <= '0;
            cnt_ff <= '0;
            lim_ff <= lim_in;
         end
         StA: begin
            xx_ff <= zx_ff * zx_ff;
            yy_ff <= zy_ff * zy_ff;
            xy_ff <= zx_ff * zy_ff;
         end
         StB: begin
            zx_ff  <= mandel_pkg::sat32(48'(dx >>> FRAC_BITS) + 48'(cx_ff));
            zy_ff  <= mandel_pkg::sat32(48'(xy_ff >>> (FRAC_BITS - 1)) + 48'(cy_ff));
            cnt_ff <= cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end
endmodule

FILE: rtl/core/mandelbrot_escape_time.sv
// Mandelbrot escape-time pixel evaluator.
// req_ beats carry a pixel column and row; each yields one rsp_ beat with
// the iteration count, the palette index (count mod 256) and a flag set when
// the cardioid or period-2 bulb test decided the point.
// csr_ writes set origin, steps and iteration limit; write only when idle.
// The front maps the pixel and runs the shortcut test, one pixel at a
// time, with a bit-serial square root. A two-entry queue decouples it
// from the back, which spends a square step, then an add-c step, on each
// iteration and also takes one pixel at a time; points that the shortcut
// test decided skip the iterations there.
// Reset is synchronous: it empties queue and pipelines and loads the
// register defaults. A stalled rsp_ holds its beat and back-pressures the
// queue, then the front, then req_tready.
module mandelbrot_escape_time #(
   parameter int FRAC_BITS  = mandel_pkg::FracBits,
   parameter int ITER_CAP   = mandel_pkg::IterCap,
   parameter int PIXEL_BITS = mandel_pkg::PixelBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2*PIXEL_BITS-1:0] req_tdata, // pixel_col, pixel_row
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // escape_count, color_index, zero fill
   output logic        rsp_tuser,  // shortcut_hit
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   logic signed [31:0] ox_ff, oy_ff;
   logic [30:0] sx_ff, sy_ff;
   logic [8:0]  mi_ff;
   logic f_valid, f_ready, b_valid, b_ready;
   mandel_pkg::job_type f_job, b_job;
   logic [8:0] count;

   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff <= -32'sd536870912;
         oy_ff <= 32'sd268435456;
         sx_ff <= 31'd1258291;
         sy_ff <= 31'd1118481;
         mi_ff <= 9'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            mandel_pkg::CsrOriginX: ox_ff <= csr_wdata;
            mandel_pkg::CsrOriginY: oy_ff <= csr_wdata;
            mandel_pkg::CsrStepX:   sx_ff <= csr_wdata[30:0];
            mandel_pkg::CsrStepY:   sy_ff <= csr_wdata[30:0];
            mandel_pkg::CsrMaxIter: mi_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   mandel_front #(.FRAC_BITS(FRAC_BITS), .PIXEL_BITS(PIXEL_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_col(req_tdata[PIXEL_BITS-1:0]),
      .in_row(req_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
      .origin_x(ox_ff), .origin_y(oy_ff), .step_x(sx_ff), .step_y(sy_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_job(f_job)
   );

   mandel_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
   );

   mandel_back #(.FRAC_BITS(FRAC_BITS), .ITER_CAP(ITER_CAP)) u_back (
      .clock, .reset,
      .in_valid(b_valid), .in_ready(b_ready), .in_job(b_job),
      .max_iter(mi_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_count(count), .out_hit(rsp_tuser)
   );

   assign rsp_tdata = {7'd0, count[7:0], count};

   a_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> count == 9'd0)
      else $error("shortcut beat with nonzero count");
   a_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(count) <= ITER_CAP)
      else $error("count above cap");
endmodule

FILE: sim/tb_top.sv
module tb_top;

   localparam logic [2:0] CsrUnused = 3'd5;
   localparam int IdleLimit = 20000;
   localparam int DrainCycles = 600;
   localparam int HoldCycles = 800;
   localparam longint One = 64'sd268435456;

   typedef struct {
      logic [8:0] count;
      logic [7:0] color;
      logic       hit;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   logic signed [31:0] view_ox, view_oy;
   logic [30:0]        view_sx, view_sy;
   logic [8:0]         view_iter;

   pixel_result_type expected_px[$];
   int errors = 0;
   int idle_cnt = 0;
   bit sink_hold = 1'b0;
   event hold_go;
   bit idle_on = 1'b1;
   int n_pixels = 0, n_shortcut = 0, n_capped = 0, n_escaped = 0;

   mandelbrot_escape_time u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [63:0] square_sat(longint v);
      logic [63:0] m;
      m = (v < 0) ? 64'(-v) : 64'(v);
      if (m >= 64'h1_0000_0000) return '1;
      return m * m;
   endfunction

   function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s < a) ? '1 : s;
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bit cardioid_or_bulb(longint x, longint y);
      longint quarter, p2;
      logic [63:0] ysq, p, bsum;
      quarter = One >>> 2;
      ysq = square_sat(y);
      p = floor_sqrt(sum_sat(square_sat(x - quarter), ysq));
      p2 = longint'((p * p) >> mandel_pkg::FracBits);
      if (x + 2 * p2 < longint'(p) + quarter) return 1'b1;
      bsum = sum_sat(square_sat(x + One), ysq);
      return (bsum >> mandel_pkg::FracBits) < (64'd1 << (mandel_pkg::FracBits - 4));
   endfunction

   function automatic pixel_result_type escape_time(logic [11:0] col, logic [11:0] row);
      pixel_result_type r;
      longint cx, cy, zx, zy, nx, ny;
      int lim, cnt;
      logic [63:0] r2;
      cx = clamp32(longint'(view_ox) + longint'(col) * longint'(view_sx));
      cy = clamp32(longint'(view_oy) - longint'(row) * longint'(view_sy));
      lim = (view_iter > mandel_pkg::IterCap) ? mandel_pkg::IterCap : view_iter;
      cnt = 0;
      r.hit = cardioid_or_bulb(cx, cy);
      if (!r.hit) begin
         zx = 0;
         zy = 0;
         while (cnt < lim) begin
            r2 = square_sat(zx) + square_sat(zy);
            if ((r2 >> mandel_pkg::FracBits) >= (64'd4 << mandel_pkg::FracBits)) break;
            nx = ((zx * zx - zy * zy) >>> mandel_pkg::FracBits) + cx;
            ny = ((zx * zy) >>> (mandel_pkg::FracBits - 1)) + cy;
            zx = clamp32(nx);
            zy = clamp32(ny);
            cnt++;
         end
      end
      r.count = cnt[8:0];
      r.color = cnt[7:0];
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // predict on req beats, check on rsp beats
   always @(posedge clock) begin
      pixel_result_type e;
      if (req_tvalid && req_tready) begin
         expected_px.push_back(escape_time(req_tdata[11:0], req_tdata[23:12]));
      end
      if (rsp_tvalid && rsp_tready) begin
         if (expected_px.size() == 0) begin
            report("unexpected beat", rsp_tdata[8:0], -1);
         end else begin
            e = expected_px.pop_front();
            n_pixels++;
            if (e.hit) n_shortcut++;
            else if (e.count == ((view_iter > mandel_pkg::IterCap) ?
                                 mandel_pkg::IterCap : view_iter)) n_capped++;
            else n_escaped++;
            if (rsp_tdata[8:0] !== e.count) report("escape_count", rsp_tdata[8:0], e.count);
            if (rsp_tdata[16:9] !== e.color) report("color_index", rsp_tdata[16:9], e.color);
            if (rsp_tuser !== e.hit) report("shortcut_hit", rsp_tuser, e.hit);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt > IdleLimit) begin
         $display("watchdog expired, %0d beats outstanding", expected_px.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // count out a long sink hold-off
   always begin
      @(hold_go);
      sink_hold = 1'b1;
      repeat (HoldCycles) @(negedge clock);
      sink_hold = 1'b0;
   end

   // hold off the sink, else stall at random
   always @(negedge clock) begin
      rsp_tready <= !(sink_hold || (idle_on && $urandom_range(99) < 13));
   end

   task automatic send_pixel(logic [11:0] col, logic [11:0] row);
      @(negedge clock);
      if (idle_on && $urandom_range(99) < 13) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {row, col};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_px.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         mandel_pkg::CsrOriginX: view_ox = value;
         mandel_pkg::CsrOriginY: view_oy = value;
         mandel_pkg::CsrStepX:   view_sx = value[30:0];
         mandel_pkg::CsrStepY:   view_sy = value[30:0];
         mandel_pkg::CsrMaxIter: view_iter = value[8:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_view(int ox, int oy, int sx, int sy, int iters);
      csr_write(mandel_pkg::CsrOriginX, ox);
      csr_write(mandel_pkg::CsrOriginY, oy);
      csr_write(mandel_pkg::CsrStepX, sx);
      csr_write(mandel_pkg::CsrStepY, sy);
      csr_write(mandel_pkg::CsrMaxIter, iters);
   endtask

   task automatic test_reset_view();
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd400, 12'd100);
      send_pixel(12'd100, 12'd0);
      wait_idle();
   endtask

   task automatic test_special_points();
      // origin on the cardioid, then the bulb centre
      set_view(0, 0, 0, 0, 256);
      send_pixel(12'd0, 12'd0);
      wait_idle();
      csr_write(mandel_pkg::CsrOriginX, -268435456);
      send_pixel(12'd7, 12'd9);
      wait_idle();
      // saturate both axes
      set_view(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 20);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd0);
      wait_idle();
      set_view(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 20);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd1, 12'd0);
      wait_idle();
      // zero, one and oversized iteration limits
      set_view(-201326592, 26843545, 16, 16, 0);
      send_pixel(12'd3, 12'd2);
      wait_idle();
      csr_write(mandel_pkg::CsrMaxIter, 1);
      send_pixel(12'd3, 12'd2);
      wait_idle();
      csr_write(mandel_pkg::CsrMaxIter, 511);
      send_pixel(12'd3, 12'd2);
      wait_idle();
      csr_write(CsrUnused, 32'hffffffff);
      send_pixel(12'd3, 12'd2);
      wait_idle();
      csr_write(mandel_pkg::CsrMaxIter, 256);
      send_pixel(12'd2048, 12'd2048);
      wait_idle();
   endtask

   task automatic random_view();
      int iters;
      case ($urandom_range(9))
         0: iters = 256;
         1: iters = $urandom_range(257, 511);
         2: iters = $urandom_range(65, 200);
         default: iters = $urandom_range(1, 64);
      endcase
      if ($urandom_range(3) == 0)
         set_view($urandom, $urandom, $urandom, $urandom, iters);
      else
         set_view(-671088640 + $urandom_range(0, 536870912),
                  $urandom_range(0, 402653184),
                  $urandom_range(1 << 12, 1 << 18), $urandom_range(1 << 12, 1 << 18),
                  iters);
   endtask

   task automatic test_random_views();
      int items;
      for (int ph = 0; ph < 35; ph++) begin
         random_view();
         idle_on = (ph != 5);
         items = (view_iter >= 200) ? 15 : 50;
         repeat (items) send_pixel(12'($urandom), 12'($urandom));
         wait_idle();
      end
      idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      set_view(-671088640, 201326592, 1 << 16, 1 << 16, 12);
      -> hold_go;
      repeat (25) send_pixel(12'($urandom), 12'($urandom));
      wait_idle();
   endtask

   initial begin
      view_ox = -536870912;
      view_oy = 268435456;
      view_sx = 1258291;
      view_sy = 1118481;
      view_iter = 256;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_view();
      test_special_points();
      test_backpressure();
      test_random_views();
      wait_idle();
      repeat (DrainCycles) @(posedge clock);
      if (expected_px.size() != 0) report("results missing", expected_px.size(), 0);
      $display("covered %0d pixels: %0d shortcut, %0d at the limit, %0d escaped",
               n_pixels, n_shortcut, n_capped, n_escaped);
      if (errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
